// ===== sv/smf_pkg.sv =====
// Shared constants, pixel type and median networks for the separable median filter.
`default_nettype none
package smf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int LINE_ROWS      = 8;
    localparam int LINE_ROW_W     = 3;
    localparam int CFG_DATA_W     = 13;

    typedef logic [7:0] pixel_t;

    // window_mode codes; the unused code behaves as pass-through
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MED3 = 2'd1;
    localparam logic [1:0] MODE_MED5 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_MODE  = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [1:0]  MODE_RESET   = MODE_MED3;
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t lo;
        pixel_t hi;
        pixel_t mid;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

    function automatic pixel_t med5(input pixel_t a, input pixel_t b, input pixel_t c,
                                    input pixel_t d, input pixel_t e);
        pixel_t p0;
        pixel_t p1;
        pixel_t p2;
        pixel_t p3;
        pixel_t p4;
        pixel_t t;
        p0 = a; p1 = b; p2 = c; p3 = d; p4 = e;
        if (p0 > p1) begin t = p0; p0 = p1; p1 = t; end
        if (p3 > p4) begin t = p3; p3 = p4; p4 = t; end
        if (p0 > p3) begin t = p0; p0 = p3; p3 = t; end
        if (p1 > p4) begin t = p1; p1 = p4; p4 = t; end
        if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
        if (p2 > p3) begin t = p2; p2 = p3; p3 = t; end
        if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
        return p2;
    endfunction

endpackage
`default_nettype wire

// ===== sv/smf_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module smf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read returns the old contents on a same-address write
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/separable_median_image_filter_unit.sv =====
// Pipeline: a result passes through the stage-1 registers, the stage-2 registers and the
// output register.
// Throughput: one transaction per cycle while in_stall is low; the raw line store, eight
// median line banks and both compare networks take one access per cycle, no iteration.
// Reset: counters and pipeline valids clear, registers return to mode 1, 640 x 480;
// line stores are not cleared and are read only after being written in the frame.
`default_nettype none
module separable_median_image_filter_unit
    import smf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [7:0]            pixel_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 pixel_out,
    output logic                       frame_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = WW + 1;
    localparam int RW    = HW + 1;
    localparam int PW    = $clog2(2 * MAX_WIDTH + 4);
    localparam int RAW_DEPTH = LINE_ROWS * (1 << COL_W);

    // configuration
    logic [1:0]  mode_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  h;
    logic [2:0]  h2;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] ht_eff;
    logic [PW-1:0] lag;
    logic cfg_write;
    logic cfg_hit;

    // stream counters
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [PW-1:0]    pending_reg, pending_next;
    pixel_t           hist_reg [4];

    // pipeline control
    logic en1, en2, en_out;
    logic accept;
    logic frame_done, do_acc, do_emit, do_hwr, do_med, do_last;

    // stage 1
    logic                  s1_valid_reg, s1_acc_reg, s1_emit_reg, s1_hwr_reg;
    logic                  s1_med_reg, s1_last_reg, s1_h2_reg;
    pixel_t                s1_taps_reg [5];
    logic [LINE_ROW_W-1:0] s1_wr_row_reg, s1_rd_row_reg, s1_base_reg;
    logic [COL_W-1:0]      s1_wr_col_reg, s1_hcol_reg, s1_rd_col_reg;
    pixel_t                hmed_val;

    // stage 2
    logic                  s2_valid_reg, s2_emit_reg, s2_med_reg, s2_last_reg, s2_h2_reg;
    logic                  s2_raw_byp_reg, s2_hbyp_reg;
    pixel_t                s2_px_reg, s2_hval_reg;
    logic [LINE_ROW_W-1:0] s2_base_reg, s2_hbank_reg;
    pixel_t                raw_rd;
    pixel_t                hmed_rd [LINE_ROWS];
    pixel_t                vtap [5];
    pixel_t                result;

    logic out_valid_reg;
    pixel_t pixel_out_reg;
    logic frame_last_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write && ((cfg_index == REG_WINDOW_MODE) ||
                                     (cfg_index == REG_FRAME_WIDTH) ||
                                     (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_MODE:  mode_reg   <= cfg_data[1:0];
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_MED3: h = 2'd1;
            MODE_MED5: h = 2'd2;
            default:   h = 2'd0;
        endcase
        h2 = {h, 1'b0};
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            ht_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            ht_eff = HW'(MAX_HEIGHT);
        else
            ht_eff = HW'(height_reg);
        unique case (h)
            2'd1:    lag = PW'(w_eff) + PW'(1);
            2'd2:    lag = PW'({w_eff, 1'b0}) + PW'(2);
            default: lag = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    // ---------------- stage 0: counters and decisions ----------------
    always_comb
    begin
        frame_done = (in_row_reg == '0) && (in_col_reg == '0) && (pending_reg != '0);
        do_acc     = accept && (command == 1'b0) && !frame_done;
        do_emit    = do_acc ? (pending_reg >= lag) : (accept && command && frame_done);
        do_hwr     = do_acc && (h != 2'd0)
                     && (CW'(in_col_reg) >= CW'(h2))
                     && (RW'(in_row_reg) >= RW'(h))
                     && (RW'(in_row_reg) + RW'(h) < RW'(ht_eff));
        do_med     = (h != 2'd0)
                     && (RW'(out_row_reg) >= RW'(h2))
                     && (RW'(out_row_reg) + RW'(h2) < RW'(ht_eff))
                     && (CW'(out_col_reg) >= CW'(h2))
                     && (CW'(out_col_reg) + CW'(h2) < CW'(w_eff));
        do_last    = (RW'(out_row_reg) + RW'(1) == RW'(ht_eff))
                     && (CW'(out_col_reg) + CW'(1) == CW'(w_eff));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        if (do_acc)
        begin
            if (CW'(in_col_reg) + CW'(1) >= CW'(w_eff))
            begin
                in_col_next = '0;
                if (RW'(in_row_reg) + RW'(1) >= RW'(ht_eff))
                    in_row_next = '0;
                else
                    in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
        if (do_emit)
        begin
            if (CW'(out_col_reg) + CW'(1) >= CW'(w_eff))
            begin
                out_col_next = '0;
                if (RW'(out_row_reg) + RW'(1) >= RW'(ht_eff))
                    out_row_next = '0;
                else
                    out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
        if (do_acc && !do_emit)
            pending_next = pending_reg + PW'(1);
        else if (!do_acc && do_emit)
            pending_next = pending_reg - PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else if (cfg_hit)
        begin
            // any register write aborts the frame
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    // recent pixels of the current row, newest first
    always_ff @(posedge clk)
    begin
        if (do_acc)
        begin
            hist_reg[0] <= pixel_in;
            hist_reg[1] <= hist_reg[0];
            hist_reg[2] <= hist_reg[1];
            hist_reg[3] <= hist_reg[2];
        end
    end

    // ---------------- stage 1: horizontal median, line store access ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_acc_reg     <= do_acc;
            s1_emit_reg    <= do_emit;
            s1_hwr_reg     <= do_hwr;
            s1_med_reg     <= do_med;
            s1_last_reg    <= do_last;
            s1_h2_reg      <= (h == 2'd2);
            s1_taps_reg[0] <= pixel_in;
            s1_taps_reg[1] <= hist_reg[0];
            s1_taps_reg[2] <= hist_reg[1];
            s1_taps_reg[3] <= hist_reg[2];
            s1_taps_reg[4] <= hist_reg[3];
            s1_wr_row_reg  <= in_row_reg[LINE_ROW_W-1:0];
            s1_wr_col_reg  <= in_col_reg;
            s1_hcol_reg    <= in_col_reg - COL_W'(h);
            s1_rd_row_reg  <= out_row_reg[LINE_ROW_W-1:0];
            s1_rd_col_reg  <= out_col_reg;
            s1_base_reg    <= out_row_reg[LINE_ROW_W-1:0] - LINE_ROW_W'(h);
        end
    end

    assign hmed_val = s1_h2_reg
        ? med5(s1_taps_reg[0], s1_taps_reg[1], s1_taps_reg[2], s1_taps_reg[3], s1_taps_reg[4])
        : med3(s1_taps_reg[0], s1_taps_reg[1], s1_taps_reg[2]);

    smf_ram #(
        .DATA_W (8),
        .DEPTH  (RAW_DEPTH)
    ) u_raw_ram (
        .clk     (clk),
        .wr_en   (en2 && s1_valid_reg && s1_acc_reg),
        .wr_addr ({s1_wr_row_reg, s1_wr_col_reg}),
        .wr_data (s1_taps_reg[0]),
        .rd_en   (en2),
        .rd_addr ({s1_rd_row_reg, s1_rd_col_reg}),
        .rd_data (raw_rd)
    );

    for (genvar k = 0; k < LINE_ROWS; k++)
    begin : g_hmed
        smf_ram #(
            .DATA_W (8),
            .DEPTH  (1 << COL_W)
        ) u_hmed_ram (
            .clk     (clk),
            .wr_en   (en2 && s1_valid_reg && s1_hwr_reg
                      && (s1_wr_row_reg == LINE_ROW_W'(k))),
            .wr_addr (s1_hcol_reg),
            .wr_data (hmed_val),
            .rd_en   (en2),
            .rd_addr (s1_rd_col_reg),
            .rd_data (hmed_rd[k])
        );
    end

    // ---------------- stage 2: vertical median ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_emit_reg    <= s1_emit_reg;
            s2_med_reg     <= s1_med_reg;
            s2_last_reg    <= s1_last_reg;
            s2_h2_reg      <= s1_h2_reg;
            s2_base_reg    <= s1_base_reg;
            s2_px_reg      <= s1_taps_reg[0];
            // forward the writes made at the same edge as the reads
            s2_raw_byp_reg <= s1_acc_reg && (s1_wr_row_reg == s1_rd_row_reg)
                              && (s1_wr_col_reg == s1_rd_col_reg);
            s2_hbyp_reg    <= s1_hwr_reg && (s1_hcol_reg == s1_rd_col_reg);
            s2_hbank_reg   <= s1_wr_row_reg;
            s2_hval_reg    <= hmed_val;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            if (s2_hbyp_reg && (s2_base_reg + LINE_ROW_W'(k) == s2_hbank_reg))
                vtap[k] = s2_hval_reg;
            else
                vtap[k] = hmed_rd[s2_base_reg + LINE_ROW_W'(k)];
        end
        if (s2_med_reg)
            result = s2_h2_reg ? med5(vtap[0], vtap[1], vtap[2], vtap[3], vtap[4])
                               : med3(vtap[0], vtap[1], vtap[2]);
        else
            result = s2_raw_byp_reg ? s2_px_reg : raw_rd;
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg && s2_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg && s2_emit_reg)
        begin
            pixel_out_reg  <= result;
            frame_last_reg <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= lag)
        else $error("pending transactions exceed the window lag");

    a_in_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(in_col_reg) < CW'(w_eff))
        else $error("input column beyond frame width");

    a_out_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(out_col_reg) < CW'(w_eff))
        else $error("output column beyond frame width");
`endif

endmodule
`default_nettype wire

// ===== tb/separable_median_image_filter_unit_tb.sv =====
// Self-checking testbench for the separable median image filter unit.
`default_nettype none
module separable_median_image_filter_unit_tb;
    import smf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // unused window_mode code, behaves as pass-through
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [7:0]            pixel_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            pixel_out;
    logic                  frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } filt_result_t;

    filt_result_t expected_pixels[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    // predictor state
    pixel_t      raw_rows[LINE_ROWS][MAX_WIDTH_DEF];
    pixel_t      hmed_rows[LINE_ROWS][MAX_WIDTH_DEF];
    logic [1:0]  cur_mode;
    logic [10:0] cur_width;
    logic [12:0] cur_height;
    int          in_col, in_row, out_col, out_row, pending;

    separable_median_image_filter_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_out(pixel_out), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int half_of_mode();
        if (cur_mode == MODE_MED3) return 1;
        if (cur_mode == MODE_MED5) return 2;
        return 0;
    endfunction

    function automatic int width_eff();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return cur_width;
    endfunction

    function automatic int height_eff();
        if (cur_height == 0) return 1;
        if (cur_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return cur_height;
    endfunction

    function automatic pixel_t median_of(int h, pixel_t t[5]);
        pixel_t s;
        int     i, j;
        int     n;
        n = 2 * h + 1;
        for (i = 0; i < n; i++)
            for (j = 0; j + 1 < n - i; j++)
                if (t[j] > t[j + 1])
                begin
                    s = t[j]; t[j] = t[j + 1]; t[j + 1] = s;
                end
        return t[h];
    endfunction

    function automatic filt_result_t next_output();
        filt_result_t res;
        pixel_t       taps[5];
        int           h, w, ht, r, c, k;
        h = half_of_mode(); w = width_eff(); ht = height_eff();
        r = out_row; c = out_col;
        res.px = raw_rows[r % LINE_ROWS][c];
        if (h != 0 && r >= 2 * h && r + 2 * h < ht && c >= 2 * h && c + 2 * h < w)
        begin
            for (k = 0; k < 5; k++)
                taps[k] = (k <= 2 * h) ? hmed_rows[(r - h + k) % LINE_ROWS][c] : 8'd0;
            res.px = median_of(h, taps);
        end
        res.last = (r == ht - 1 && c == w - 1);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= ht) out_row = 0;
        end
        return res;
    endfunction

    function automatic void store_pixel(pixel_t px);
        pixel_t taps[5];
        int     h, w, ht, r, c, k;
        h = half_of_mode(); w = width_eff(); ht = height_eff();
        r = in_row;
        raw_rows[r % LINE_ROWS][in_col] = px;
        if (h != 0 && in_col >= 2 * h && r >= h && r + h < ht)
        begin
            c = in_col - h;
            for (k = 0; k < 5; k++)
                taps[k] = (k <= 2 * h) ? raw_rows[r % LINE_ROWS][c - h + k] : 8'd0;
            hmed_rows[r % LINE_ROWS][c] = median_of(h, taps);
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
            if (in_row >= ht) in_row = 0;
        end
    endfunction

    function automatic void predict_filter(logic cmd, pixel_t px);
        int  lag;
        bit  done;
        lag  = half_of_mode() * width_eff() + half_of_mode();
        done = (in_row == 0 && in_col == 0 && pending > 0);
        if (cmd == CMD_PIXEL)
        begin
            if (done) return;
            store_pixel(px);
            pending++;
            if (pending > lag)
            begin
                expected_pixels.push_back(next_output());
                pending--;
            end
        end
        else if (done)
        begin
            expected_pixels.push_back(next_output());
            pending--;
        end
    endfunction

    // receiver: random stall and result check
    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t exp_res;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result px=%0h last=%0b", $time, pixel_out,
                             frame_last);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_pixels.pop_front();
                    if (pixel_out !== exp_res.px)
                    begin
                        $display("%0t: pixel_out expected %0h actual %0h", $time,
                                 exp_res.px, pixel_out);
                        error_count++;
                    end
                    if (frame_last !== exp_res.last)
                    begin
                        $display("%0t: frame_last expected %0b actual %0b", $time,
                                 exp_res.last, frame_last);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // leave valid high after the transaction; the next call or wait_drained drives it
    task automatic send_item(logic cmd, pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_filter(cmd, px);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // leave valid high after the write; setup_frame drops it
    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_WINDOW_MODE) cur_mode = val[1:0];
        else if (idx == REG_FRAME_WIDTH) cur_width = val[10:0];
        else cur_height = val[12:0];
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
    endtask

    task automatic setup_frame(logic [1:0] mode, int w, int h);
        wait_drained();
        write_reg(REG_WINDOW_MODE, CFG_DATA_W'(mode));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        cfg_valid <= 1'b0;
    endtask

    // send one frame, optionally with noise, then drain it
    task automatic run_frame(int flat_pct, bit noise);
        int     n, i;
        pixel_t px;
        n = width_eff() * height_eff();
        for (i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(9) == 0) send_item(CMD_DRAIN, pixel_t'($urandom));
            px = ($urandom_range(99) < flat_pct) ? 8'd128 : pixel_t'($urandom);
            send_item(CMD_PIXEL, px);
        end
        if (noise) send_item(CMD_PIXEL, pixel_t'($urandom));
        while (pending > 0) send_item(CMD_DRAIN, pixel_t'($urandom));
        send_item(CMD_DRAIN, 8'hFF);
    endtask

    task automatic test_directed();
        // extremes, pass-through, unused mode, clamped sizes, small frame
        setup_frame(MODE_MED3, 4, 3);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'h55);
        run_frame(0, 1'b0);
        setup_frame(MODE_PASS, 0, 0);
        send_item(CMD_PIXEL, 8'hAA);
        send_item(CMD_PIXEL, 8'h55);
        send_item(CMD_DRAIN, 8'h00);
        setup_frame(MODE_UNUSED, 3, 2);
        run_frame(0, 1'b0);
        setup_frame(MODE_MED5, 2047, 1);
        for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, 8'hFF);
        setup_frame(MODE_MED3, 2, 8191);
        for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, pixel_t'(i * 85));
        wait_drained();
    endtask

    task automatic test_median3();
        setup_frame(MODE_MED3, 7, 6);
        run_frame(30, 1'b1);
        setup_frame(MODE_MED3, 9, 8);
        run_frame(0, 1'b0);
    endtask

    task automatic test_median5();
        setup_frame(MODE_MED5, 9, 8);
        run_frame(20, 1'b1);
        setup_frame(MODE_MED5, 12, 10);
        run_frame(0, 1'b0);
    endtask

    task automatic test_random_frames();
        logic [1:0] mode;
        for (int f = 0; f < 3; f++)
        begin
            mode = 2'($urandom_range(3));
            setup_frame(mode, $urandom_range(1, 14), $urandom_range(1, 12));
            run_frame($urandom_range(50), ($urandom_range(1) == 1));
        end
    endtask

    initial
    begin
        error_count   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 70;
        cur_mode   = MODE_RESET;
        cur_width  = WIDTH_RESET;
        cur_height = HEIGHT_RESET;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = 1'b0;
        pixel_in  = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_MODE;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_median3();
        test_median5();
        test_random_frames();
        send_idle_pct = 70;
        recv_idle_pct = 31;
        test_median3();
        test_random_frames();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_median5();
        test_random_frames();

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
